// File: sv/sgs_pkg.sv
package sgs_pkg;

  // scene region picked by the squared radius and the row
  typedef enum logic [1:0] {
    REG_SKY,
    REG_SPHERE,
    REG_GROUND
  } region_e;

  // register stages inside the shading pipe, counting the output stage
  localparam int unsigned PIPE_DEPTH = 8;

  localparam logic signed [7:0] CENTRE_X   = 8'sd36;
  localparam logic signed [6:0] CENTRE_Y   = 7'sd18;
  localparam logic [13:0]       SPHERE_R2  = 14'd200;
  localparam logic [12:0]       T_BASE     = 13'd5200;
  localparam logic [11:0]       SPH_RED    = 12'd420;
  localparam logic [10:0]       SPH_BLUE   = 11'd520;
  localparam logic [11:0]       SPH_OFFS   = 12'd900;
  localparam logic [8:0]        GND_RED    = 9'd150;
  localparam logic [7:0]        GND_BLUE   = 8'd50;
  localparam logic [15:0]       GND_CMIN   = 16'd1200;
  localparam logic [14:0]       GND_EBASE  = 15'd7840;
  localparam logic [13:0]       GND_OOFFS  = 14'd8560;
  localparam logic [11:0]       GND_DBASE  = 12'd3200;
  localparam logic [7:0]        GND_SLOPE  = 8'd240;
  localparam logic [7:0]        SKY_RED    = 8'd132;
  localparam logic [7:0]        SKY_BLUE   = 8'd192;
  localparam logic [3:0]        GRN_RED_WT = 4'd11;
  localparam logic [3:0]        GRN_BLU_WT = 4'd5;

endpackage

// File: sv/sgs_pipe.sv
module sgs_pipe (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  logic [6:0] x_coord_i,
  input  logic [5:0] y_coord_i,
  output logic       vld_o,
  output logic [7:0] red_o,
  output logic [7:0] blue_o
);

  function automatic logic [7:0] clamp8(input logic signed [19:0] a);
    logic [7:0] r;
    if (a < 20'sd0) begin
      r = 8'd0;
    end else if (a > 20'sd255) begin
      r = 8'd255;
    end else begin
      r = a[7:0];
    end
    return r;
  endfunction

  logic [sgs_pkg::PIPE_DEPTH-1:0] vld_q;

  // stage 1: centre and square
  logic signed [7:0]  u1_d, u1_q;
  logic signed [6:0]  v1_d, v1_q;
  logic signed [15:0] uu_full;
  logic signed [13:0] vv_full;
  logic signed [14:0] uv_full;
  logic [13:0]        uu1_q;
  logic [10:0]        vv1_q;
  logic signed [12:0] uv1_q;
  logic [8:0]         sky1_d, sky1_q;

  assign u1_d    = $signed({1'b0, x_coord_i}) - sgs_pkg::CENTRE_X;
  assign v1_d    = sgs_pkg::CENTRE_Y - $signed({1'b0, y_coord_i});
  assign uu_full = u1_d * u1_d;
  assign vv_full = v1_d * v1_d;
  assign uv_full = u1_d * v1_d;
  assign sky1_d  = {2'b00, x_coord_i} + {1'b0, y_coord_i, 2'b00};

  // stage 2: radius, region, sphere scale
  logic [13:0]           h2_d, h2_q;
  logic [12:0]           t2_d, t2_q;
  logic [14:0]           pg2_d, pg2_q;
  sgs_pkg::region_e      reg2_d, reg2_q;
  logic signed [7:0]     u2_q;
  logic signed [6:0]     v2_q;
  logic signed [12:0]    uv2_q;
  logic [8:0]            sky2_q;

  assign h2_d  = uu1_q + {3'b000, vv1_q};
  assign t2_d  = sgs_pkg::T_BASE + {2'b00, h2_d[7:0], 3'b000};
  assign pg2_d = {1'b0, h2_d} + {1'b0, vv1_q, 3'b000};

  always_comb begin
    if (h2_d < sgs_pkg::SPHERE_R2) begin
      reg2_d = sgs_pkg::REG_SPHERE;
    end else if (v1_q[6]) begin
      reg2_d = sgs_pkg::REG_GROUND;
    end else begin
      reg2_d = sgs_pkg::REG_SKY;
    end
  end

  // stage 3: sphere normal terms, ground falloff
  logic signed [21:0] tu;
  logic signed [20:0] tv;
  logic signed [16:0] cw;
  logic signed [10:0] p3_d, p3_q, q3_d, q3_q;
  logic signed [15:0] c3_d, c3_q;
  logic signed [8:0]  rg03_d, rg03_q;
  logic [13:0]        h3_q;
  logic signed [12:0] uv3_q;
  logic [8:0]         sky3_q;
  sgs_pkg::region_e   reg3_q;

  assign tu     = $signed({1'b0, t2_q}) * u2_q;
  assign tv     = $signed({1'b0, t2_q}) * v2_q;
  assign p3_d   = tu[17:7];
  assign q3_d   = tv[17:7];
  assign cw     = -($signed({9'b0, sgs_pkg::GND_SLOPE}) * v2_q) - $signed({2'b00, pg2_q});
  assign c3_d   = cw[15:0];
  assign rg03_d = $signed(sgs_pkg::GND_RED) + $signed({v2_q, 1'b0});

  // stage 4: light direction, bounce, shadow exponent, occlusion
  logic signed [15:0] s4;
  logic signed [15:0] wf;
  logic signed [11:0] pq4;
  logic signed [11:0] of4;
  logic signed [20:0] c25;
  logic signed [20:0] ef;
  logic signed [19:0] df;
  logic signed [6:0]  w4_d, w4_q;
  logic [7:0]         kk4_d, kk4_q;
  logic [10:0]        o4_d, o4_q;
  logic signed [15:0] e4_d, e4_q;
  logic               cgt4_d, cgt4_q;
  logic [16:0]        d4_d, d4_q;
  logic signed [15:0] c4_q;
  logic signed [8:0]  rg04_q;
  logic [8:0]         sky4_q;
  sgs_pkg::region_e   reg4_q;

  assign s4     = 16'sd5 * p3_q - 16'sd13 * q3_q;
  assign wf     = 16'sd18 + (s4 >>> 9);
  assign w4_d   = wf[6:0];
  assign pq4    = {p3_q[10], p3_q} + {q3_q[10], q3_q};
  // bounce term only where the sphere faces the key light
  assign kk4_d  = (!pq4[11] && pq4 != 12'sd0) ? pq4[10:3] : 8'd0;
  assign of4    = {q3_q[10], q3_q} + $signed(sgs_pkg::SPH_OFFS);
  assign o4_d   = of4[10:0];
  assign c25    = 21'sd25 * c3_q;
  assign ef     = $signed({6'b0, sgs_pkg::GND_EBASE}) - (c25 >>> 3);
  assign e4_d   = ef[15:0];
  assign cgt4_d = c3_q > $signed(sgs_pkg::GND_CMIN);
  assign df     = $signed({8'b0, sgs_pkg::GND_DBASE}) - $signed({6'b0, h3_q})
                  - (20'(c3_q) <<< 1) - (20'(uv3_q) <<< 1);
  assign d4_d   = (!df[19] && df != 20'sd0) ? df[16:0] : 17'd0;

  // stage 5: key light square, shadow product
  logic signed [13:0] wwf;
  logic signed [31:0] mf;
  logic [11:0]        rp5_d, rp5_q;
  logic signed [29:0] m5_d, m5_q;
  logic [10:0]        o5_q;
  logic [7:0]         kk5_q;
  logic               cgt5_q;
  logic signed [8:0]  rg05_q;
  logic [16:0]        d5_q;
  logic [8:0]         sky5_q;
  sgs_pkg::region_e   reg5_q;

  assign wwf   = w4_q * w4_q;
  assign rp5_d = sgs_pkg::SPH_RED
                 + {1'b0, (!w4_q[6] && w4_q != 7'sd0) ? wwf[10:0] : 11'd0};
  assign mf    = c4_q * e4_q;
  assign m5_d  = mf[29:0];

  // stage 6: sphere shading products, shadow factor
  logic [22:0]        rsf;
  logic [20:0]        bsf;
  logic signed [29:0] ogw;
  logic [21:0]        rs6_d, rs6_q;
  logic [19:0]        bs6_d, bs6_q;
  logic signed [20:0] og6_d, og6_q;
  logic [7:0]         kk6_q;
  logic               cgt6_q;
  logic signed [8:0]  rg06_q;
  logic [16:0]        d6_q;
  logic [8:0]         sky6_q;
  sgs_pkg::region_e   reg6_q;

  assign rsf   = rp5_q * o5_q;
  assign rs6_d = rsf[21:0];
  assign bsf   = {10'b0, sgs_pkg::SPH_BLUE} * o5_q;
  assign bs6_d = bsf[19:0];
  assign ogw   = (m5_q >>> 9) - $signed({16'b0, sgs_pkg::GND_OOFFS});
  assign og6_d = ogw[20:0];

  // stage 7: per-region channels
  logic signed [29:0] rgf;
  logic signed [27:0] bgf;
  logic [10:0]        rsph7_d, rsph7_q;
  logic [9:0]         bsph7_d, bsph7_q;
  logic signed [17:0] rg7_d, rg7_q;
  logic signed [15:0] bg7_d, bg7_q;
  logic [16:0]        d7_q;
  logic [8:0]         sky7_q;
  sgs_pkg::region_e   reg7_q;

  assign rgf     = rg06_q * og6_q;
  assign bgf     = $signed({20'b0, sgs_pkg::GND_BLUE}) * og6_q;
  assign rg7_d   = cgt6_q ? rgf[27:10] : {{9{rg06_q[8]}}, rg06_q};
  assign bg7_d   = cgt6_q ? bgf[25:10] : $signed({8'b0, sgs_pkg::GND_BLUE});
  assign rsph7_d = {1'b0, rs6_q[21:12]} + {3'b000, kk6_q};
  assign bsph7_d = {2'b00, bs6_q[19:12]} + {2'b00, kk6_q};

  // stage 8: region select, ground occlusion, saturate
  logic signed [19:0] rf, bf;
  logic [7:0]         red8_q, blue8_q;
  sgs_pkg::region_e   reg8_q;

  always_comb begin
    case (reg7_q)
      sgs_pkg::REG_SPHERE: begin
        rf = $signed({9'b0, rsph7_q});
        bf = $signed({10'b0, bsph7_q});
      end
      sgs_pkg::REG_GROUND: begin
        rf = $signed({{2{rg7_q[17]}}, rg7_q}) + $signed({3'b000, d7_q});
        bf = $signed({{4{bg7_q[15]}}, bg7_q});
      end
      sgs_pkg::REG_SKY: begin
        rf = $signed({11'b0, sky7_q} + {12'b0, sgs_pkg::SKY_RED});
        bf = $signed({11'b0, sky7_q} + {12'b0, sgs_pkg::SKY_BLUE});
      end
      default: begin
        rf = 20'sd0;
        bf = 20'sd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[sgs_pkg::PIPE_DEPTH-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    u1_q   <= u1_d;
    v1_q   <= v1_d;
    uu1_q  <= uu_full[13:0];
    vv1_q  <= vv_full[10:0];
    uv1_q  <= uv_full[12:0];
    sky1_q <= sky1_d;

    h2_q   <= h2_d;
    t2_q   <= t2_d;
    pg2_q  <= pg2_d;
    reg2_q <= reg2_d;
    u2_q   <= u1_q;
    v2_q   <= v1_q;
    uv2_q  <= uv1_q;
    sky2_q <= sky1_q;

    p3_q   <= p3_d;
    q3_q   <= q3_d;
    c3_q   <= c3_d;
    rg03_q <= rg03_d;
    h3_q   <= h2_q;
    uv3_q  <= uv2_q;
    sky3_q <= sky2_q;
    reg3_q <= reg2_q;

    w4_q   <= w4_d;
    kk4_q  <= kk4_d;
    o4_q   <= o4_d;
    e4_q   <= e4_d;
    cgt4_q <= cgt4_d;
    d4_q   <= d4_d;
    c4_q   <= c3_q;
    rg04_q <= rg03_q;
    sky4_q <= sky3_q;
    reg4_q <= reg3_q;

    rp5_q  <= rp5_d;
    m5_q   <= m5_d;
    o5_q   <= o4_q;
    kk5_q  <= kk4_q;
    cgt5_q <= cgt4_q;
    rg05_q <= rg04_q;
    d5_q   <= d4_q;
    sky5_q <= sky4_q;
    reg5_q <= reg4_q;

    rs6_q  <= rs6_d;
    bs6_q  <= bs6_d;
    og6_q  <= og6_d;
    kk6_q  <= kk5_q;
    cgt6_q <= cgt5_q;
    rg06_q <= rg05_q;
    d6_q   <= d5_q;
    sky6_q <= sky5_q;
    reg6_q <= reg5_q;

    rsph7_q <= rsph7_d;
    bsph7_q <= bsph7_d;
    rg7_q   <= rg7_d;
    bg7_q   <= bg7_d;
    d7_q    <= d6_q;
    sky7_q  <= sky6_q;
    reg7_q  <= reg6_q;

    red8_q  <= clamp8(rf);
    blue8_q <= clamp8(bf);
    reg8_q  <= reg7_q;
  end

  assign vld_o  = vld_q[sgs_pkg::PIPE_DEPTH-1];
  assign red_o  = red8_q;
  assign blue_o = blue8_q;

`ifndef SYNTHESIS
  a_pipe_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> $past(vld_i, sgs_pkg::PIPE_DEPTH))
    else $error("pipe output without a matching input item");

  a_sky_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_o && reg8_q == sgs_pkg::REG_SKY && blue_o != 8'd255) |->
      (red_o + 8'd60 == blue_o))
    else $error("sky red and blue lost their fixed offset");
`endif

endmodule

// File: sv/sphere_ground_sky_pixel_shader.sv
// a result strobes on done_o once the item taken with start has passed the shading pipe and the output register
// throughput: one item per cycle, busy stays low, set by the shading pipe
// the deepest stage is one 16x16 multiply of the ground shadow term
// reset clears only the valid bits, so no strobe appears until an item drains
// results leave on done_o and cannot be stalled
module sphere_ground_sky_pixel_shader (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [6:0] x_coord_i,
  input  logic [5:0] y_coord_i,
  output logic       done_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  logic        pipe_vld;
  logic [7:0]  pipe_red;
  logic [7:0]  pipe_blue;
  logic [11:0] grn_sum;
  logic [7:0]  green_d;
  logic        done_q;
  logic [7:0]  red_q, green_q, blue_q;

  // the pipe takes an item every cycle
  assign busy = 1'b0;

  sgs_pipe u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (start && !busy),
    .x_coord_i (x_coord_i),
    .y_coord_i (y_coord_i),
    .vld_o     (pipe_vld),
    .red_o     (pipe_red),
    .blue_o    (pipe_blue)
  );

  // green mixes the saturated red and blue
  assign grn_sum = {8'b0, sgs_pkg::GRN_RED_WT} * {4'b0, pipe_red}
                 + {8'b0, sgs_pkg::GRN_BLU_WT} * {4'b0, pipe_blue};
  assign green_d = grn_sum[11:4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= pipe_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= pipe_red;
    green_q <= green_d;
    blue_q  <= pipe_blue;
  end

  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, sgs_pkg::PIPE_DEPTH + 1))
    else $error("result strobe without an item taken at the expected edge");

  a_green_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (green_o <= red_o || green_o <= blue_o))
    else $error("green exceeds both red and blue");
`endif

endmodule

// File: test/sphere_ground_sky_pixel_shader_tb.sv
module sphere_ground_sky_pixel_shader_tb;

  localparam int unsigned RANDOM_PIXELS = 2000;
  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned DRAIN_CYCLES  = sgs_pkg::PIPE_DEPTH + 4;

  typedef struct {
    logic [6:0]       x;
    logic [5:0]       y;
    sgs_pkg::region_e area;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } shaded_pixel_t;

  class pixel_scoreboard;
    shaded_pixel_t expected_pixels[$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   area_count[3];

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    static function logic [7:0] clamp_channel(longint a);
      if (a < 0) return 8'd0;
      if (a > 255) return 8'd255;
      return a[7:0];
    endfunction

    // shades one coordinate and queues the color the block should give
    function void note_pixel(logic [6:0] x, logic [5:0] y);
      shaded_pixel_t px;
      longint u, v, v2, h, t, p, q, w, o, k, c, r, d, red, blue;
      u = longint'(x) - 36;
      v = 18 - longint'(y);
      v2 = v * v;
      h = u * u + v2;
      if (h < 200) begin
        px.area = sgs_pkg::REG_SPHERE;
        t = 5200 + h * 8;
        p = (t * u) >>> 7;
        q = (t * v) >>> 7;
        w = 18 + ((p * 5 - q * 13) >>> 9);
        o = q + 900;
        red = 420;
        blue = 520;
        if (w > 0) red += w * w;
        red = (red * o) >>> 12;
        blue = (blue * o) >>> 12;
        // key light only on the side facing it
        if (p > -q) begin
          k = (p + q) >>> 3;
          red += k;
          blue += k;
        end
      end else if (v < 0) begin
        px.area = sgs_pkg::REG_GROUND;
        p = h + 8 * v2;
        c = 240 * (-v) - p;
        red = 150 + 2 * v;
        blue = 50;
        if (c > 1200) begin
          o = (25 * c) >>> 3;
          o = ((c * (7840 - o)) >>> 9) - 8560;
          red = (red * o) >>> 10;
          blue = (blue * o) >>> 10;
        end
        // shadow term under the sphere
        r = c + u * v;
        d = 3200 - h - 2 * r;
        if (d > 0) red += d;
      end else begin
        px.area = sgs_pkg::REG_SKY;
        c = longint'(x) + 4 * longint'(y);
        red = 132 + c;
        blue = 192 + c;
      end
      px.x = x;
      px.y = y;
      px.red = clamp_channel(red);
      px.blue = clamp_channel(blue);
      px.green = 8'((11 * int'(px.red) + 5 * int'(px.blue)) >> 4);
      expected_pixels.push_back(px);
    endfunction

    task check_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      shaded_pixel_t px;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("color %0d/%0d/%0d with no item waiting", red, green, blue));
        return;
      end
      px = expected_pixels.pop_front();
      checked++;
      area_count[px.area]++;
      if (red !== px.red)
        report_mismatch($sformatf("(%0d,%0d) red %0d, want %0d", px.x, px.y, red, px.red));
      if (green !== px.green)
        report_mismatch($sformatf("(%0d,%0d) green %0d, want %0d", px.x, px.y, green,
                                  px.green));
      if (blue !== px.blue)
        report_mismatch($sformatf("(%0d,%0d) blue %0d, want %0d", px.x, px.y, blue, px.blue));
    endtask

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [6:0] x_coord_i;
  logic [5:0] y_coord_i;
  logic       done_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;

  pixel_scoreboard sb;
  int unsigned     idle_cycles;

  sphere_ground_sky_pixel_shader dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .x_coord_i (x_coord_i),
    .y_coord_i (y_coord_i),
    .done_o    (done_o),
    .red_o     (red_o),
    .green_o   (green_o),
    .blue_o    (blue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_pixel(red_o, green_o, blue_o);
  end

  // ends the run if neither side moves an item for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("[sphere_ground_sky_pixel_shader] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // start stays high across back-to-back items
  task send_pixel(logic [6:0] x, logic [5:0] y);
    @(negedge clk_i);
    start <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    do @(posedge clk_i); while (busy);
    sb.note_pixel(x, y);
  endtask

  task idle_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task wait_all_shaded();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task run_directed();
    logic [6:0] xs[$];
    logic [5:0] ys[$];
    xs = '{0, 127, 127, 0, 36, 36, 49, 22, 36, 46, 26, 50, 51, 36, 36, 36, 10, 90, 127, 100,
           64, 0, 36, 85};
    ys = '{0, 63, 0, 63, 18, 5, 18, 18, 32, 8, 28, 18, 18, 33, 45, 63, 40, 60, 40, 10,
           0, 19, 19, 42};
    foreach (xs[i]) send_pixel(xs[i], ys[i]);
  endtask

  task run_random();
    int unsigned sent;
    int unsigned burst;
    int unsigned mode;
    logic [6:0]  x;
    logic [5:0]  y;
    bit          paused;
    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_PIXELS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        mode = $urandom_range(0, 9);
        if (mode < 3) begin
          // around the sphere and its rim
          x = 7'($urandom_range(22, 50));
          y = 6'($urandom_range(4, 32));
        end else if (mode < 6) begin
          x = 7'($urandom);
          y = 6'($urandom_range(19, 63));
        end else begin
          x = 7'($urandom);
          y = 6'($urandom);
        end
        send_pixel(x, y);
        sent++;
      end
      if (!paused && sent >= RANDOM_PIXELS / 2) begin
        paused = 1'b1;
        idle_sender(1);
        wait_all_shaded();
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    x_coord_i = '0;
    y_coord_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random();
    idle_sender(1);
    wait_all_shaded();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.pending() != 0) sb.report_mismatch($sformatf("%0d colors never came", sb.pending()));
    $display("shaded %0d pixels: %0d sphere, %0d ground, %0d sky; %0d mismatches",
             sb.checked, sb.area_count[sgs_pkg::REG_SPHERE],
             sb.area_count[sgs_pkg::REG_GROUND], sb.area_count[sgs_pkg::REG_SKY],
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[sphere_ground_sky_pixel_shader] OK");
    end else begin
      $display("[sphere_ground_sky_pixel_shader] ERROR");
    end
    $finish;
  end

endmodule
